### rtl/core/ibss_pkg.sv
package ibss_pkg;

    typedef enum logic [2:0] {
        OP_INSERT_AT  = 3'd0,
        OP_ERASE_AT   = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_FIND       = 3'd4,
        OP_CLEAR      = 3'd5,
        OP_PUSH_FRONT = 3'd6,
        OP_PUSH_BACK  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] position;
        logic [7:0] byte_value;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] match_position;
        logic [7:0] front_byte;
        logic [7:0] back_byte;
        logic [4:0] entry_count;
    } rsp_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_MATCH,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t   kind;
        logic [7:0] value;
    } cell_cmd_t;

endpackage

### rtl/core/ibss_cell.sv
module ibss_cell #(
    parameter int OCC_W = 5,
    parameter int IDX   = 0
) (
    input  logic                 clk,
    input  ibss_pkg::cell_cmd_t  cmd,
    input  logic [OCC_W-1:0]     at,
    input  logic [OCC_W-1:0]     occ,
    input  logic [7:0]           left_byte,
    input  logic [7:0]           right_byte,
    input  logic                 right_match,
    output logic [7:0]           data,
    output logic                 match,
    output logic [7:0]           last_byte
);

    localparam logic [OCC_W-1:0] MY_IDX = OCC_W'(IDX);

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       match_reg;
    logic       match_next;
    logic       is_last;

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        case (cmd.kind)
            ibss_pkg::CELL_INSERT:
            begin
                if (MY_IDX > at)
                begin
                    data_next = left_byte;
                end
                else if (MY_IDX == at)
                begin
                    data_next = cmd.value;
                end
            end
            ibss_pkg::CELL_ERASE:
            begin
                if (MY_IDX >= at)
                begin
                    data_next = right_byte;
                end
            end
            ibss_pkg::CELL_MATCH:
            begin
                match_next = (data_reg == cmd.value) && (MY_IDX < occ);
            end
            ibss_pkg::CELL_SHIFT:
            begin
                match_next = right_match;
            end
            default:
            begin
                data_next  = data_reg;
                match_next = match_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign is_last   = (occ != '0) && (MY_IDX == occ - OCC_W'(1));
    assign data      = data_reg;
    assign match     = match_reg;
    assign last_byte = is_last ? data_reg : 8'h00;

endmodule

### rtl/core/indexed_byte_sequence_store.sv
// Bounded ordered byte sequence held in a row of CAPACITY cells. Each request
// (insert, erase, pop, push, find, clear) returns one response carrying a
// status, the match position of a successful find, the front and back bytes
// and the count. Insert, erase, push, pop and clear are applied in the cycle
// the request is taken; insert, erase, push and pop front shift every cell at
// or past the position toward or away from its neighbor at once, while pop
// back and clear only change the count. The response is formed in the report
// state when the output is free. Find loads a match flag in every cell and
// shifts the flags down the chain one cell per cycle until the front cell
// shows a hit or all flags have reached it. A finished response waits in the
// output register without holding up the next request. A failed request
// leaves the sequence unchanged; entries beyond the count are never observed.
module indexed_byte_sequence_store #(
    parameter int CAPACITY = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ibss_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ibss_pkg::rsp_t rsp
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (OCC_W > 5) ? OCC_W : 5;
    localparam logic [OCC_W-1:0] FULL_COUNT = OCC_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REPORT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    logic [OCC_W-1:0]    cnt_reg;
    logic [OCC_W-1:0]    cnt_next;
    logic [OCC_W-1:0]    match_reg;
    logic [OCC_W-1:0]    match_next;
    ibss_pkg::status_t   status_reg;
    ibss_pkg::status_t   status_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    ibss_pkg::rsp_t      rsp_reg;
    ibss_pkg::rsp_t      rsp_next;

    ibss_pkg::cell_cmd_t cell_cmd;
    logic [OCC_W-1:0]    cell_at;
    logic [7:0]          cell_data [CAPACITY];
    logic                cell_match [CAPACITY];
    logic [7:0]          cell_last [CAPACITY];
    logic [7:0]          back_or;

    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    occ_ext;
    logic                occ_zero;
    logic                occ_full;

    assign pos_ext  = CMP_W'(req.position);
    assign occ_ext  = CMP_W'(occ_reg);
    assign occ_zero = (occ_reg == '0);
    assign occ_full = (occ_reg == FULL_COUNT);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [7:0] left_byte;
            logic [7:0] right_byte;
            logic       right_match;

            if (gi == 0)
            begin : g_first
                assign left_byte = 8'h00;
            end
            else
            begin : g_inner_l
                assign left_byte = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_byte  = 8'h00;
                assign right_match = 1'b0;
            end
            else
            begin : g_inner_r
                assign right_byte  = cell_data[gi+1];
                assign right_match = cell_match[gi+1];
            end

            ibss_cell #(
                .OCC_W (OCC_W),
                .IDX   (gi)
            ) u_cell (
                .clk         (clk),
                .cmd         (cell_cmd),
                .at          (cell_at),
                .occ         (occ_reg),
                .left_byte   (left_byte),
                .right_byte  (right_byte),
                .right_match (right_match),
                .data        (cell_data[gi]),
                .match       (cell_match[gi]),
                .last_byte   (cell_last[gi])
            );
        end
    endgenerate

    // Only the cell at the back drives a nonzero byte, so an OR picks it out.
    always_comb
    begin
        back_or = 8'h00;
        for (int i = 0; i < CAPACITY; i++)
        begin
            back_or = back_or | cell_last[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        match_next     = match_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        cell_cmd.kind  = ibss_pkg::CELL_HOLD;
        cell_cmd.value = req.byte_value;
        cell_at        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next  = S_REPORT;
                    status_next = ibss_pkg::ST_OK;
                    match_next  = '0;
                    cnt_next    = '0;
                    case (req.op)
                        ibss_pkg::OP_INSERT_AT:
                        begin
                            if (pos_ext > occ_ext)
                            begin
                                status_next = ibss_pkg::ST_RANGE;
                            end
                            else if (occ_full)
                            begin
                                status_next = ibss_pkg::ST_FULL;
                            end
                            else
                            begin
                                cell_cmd.kind = ibss_pkg::CELL_INSERT;
                                cell_at       = OCC_W'(req.position);
                                occ_next      = occ_reg + OCC_W'(1);
                            end
                        end
                        ibss_pkg::OP_ERASE_AT:
                        begin
                            if (occ_zero)
                            begin
                                status_next = ibss_pkg::ST_EMPTY;
                            end
                            else if (pos_ext >= occ_ext)
                            begin
                                status_next = ibss_pkg::ST_RANGE;
                            end
                            else
                            begin
                                cell_cmd.kind = ibss_pkg::CELL_ERASE;
                                cell_at       = OCC_W'(req.position);
                                occ_next      = occ_reg - OCC_W'(1);
                            end
                        end
                        ibss_pkg::OP_POP_FRONT:
                        begin
                            if (occ_zero)
                            begin
                                status_next = ibss_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cell_cmd.kind = ibss_pkg::CELL_ERASE;
                                occ_next      = occ_reg - OCC_W'(1);
                            end
                        end
                        ibss_pkg::OP_POP_BACK:
                        begin
                            if (occ_zero)
                            begin
                                status_next = ibss_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // Dropping the count alone removes the back entry.
                                occ_next = occ_reg - OCC_W'(1);
                            end
                        end
                        ibss_pkg::OP_FIND:
                        begin
                            if (occ_zero)
                            begin
                                status_next = ibss_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cell_cmd.kind = ibss_pkg::CELL_MATCH;
                                state_next    = S_SCAN;
                            end
                        end
                        ibss_pkg::OP_CLEAR:
                        begin
                            occ_next = '0;
                        end
                        ibss_pkg::OP_PUSH_FRONT:
                        begin
                            if (occ_full)
                            begin
                                status_next = ibss_pkg::ST_FULL;
                            end
                            else
                            begin
                                cell_cmd.kind = ibss_pkg::CELL_INSERT;
                                occ_next      = occ_reg + OCC_W'(1);
                            end
                        end
                        ibss_pkg::OP_PUSH_BACK:
                        begin
                            if (occ_full)
                            begin
                                status_next = ibss_pkg::ST_FULL;
                            end
                            else
                            begin
                                cell_cmd.kind = ibss_pkg::CELL_INSERT;
                                cell_at       = occ_reg;
                                occ_next      = occ_reg + OCC_W'(1);
                            end
                        end
                        default:
                        begin
                            status_next = ibss_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // The count tells how many shifts the match flags have made.
                if (cell_match[0])
                begin
                    status_next = ibss_pkg::ST_OK;
                    match_next  = cnt_reg;
                    state_next  = S_REPORT;
                end
                else if (cnt_reg == occ_reg - OCC_W'(1))
                begin
                    status_next = ibss_pkg::ST_NOTFOUND;
                    state_next  = S_REPORT;
                end
                else
                begin
                    cell_cmd.kind = ibss_pkg::CELL_SHIFT;
                    cnt_next      = cnt_reg + OCC_W'(1);
                end
            end

            S_REPORT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.status         = status_reg;
                    rsp_next.match_position = 4'(match_reg);
                    rsp_next.front_byte     = occ_zero ? 8'h00 : cell_data[0];
                    rsp_next.back_byte      = occ_zero ? 8'h00 : back_or;
                    rsp_next.entry_count    = 5'(occ_reg);
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            match_reg     <= '0;
            status_reg    <= ibss_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            match_reg     <= match_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/core/ibss_checker.sv
module ibss_checker #(
    parameter int CAPACITY = 16
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input ibss_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input ibss_pkg::rsp_t rsp
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request dropped or changed while stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response dropped or changed while stalled");

    // An empty sequence shows no front or back byte.
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.entry_count == 5'd0) && (CAPACITY < 32)
        |-> (rsp.front_byte == 8'h00) && (rsp.back_byte == 8'h00))
        else $error("empty sequence reports a nonzero end byte");

    a_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ibss_pkg::ST_OK) |-> rsp.match_position == 4'd0)
        else $error("failed request reports a match position");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ibss_pkg::ST_FULL) |-> rsp.entry_count == 5'(CAPACITY))
        else $error("full status with a count below capacity");

endmodule

bind indexed_byte_sequence_store ibss_checker #(
    .CAPACITY (CAPACITY)
) u_ibss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
